// ----- rtl/mf3_pkg.sv -----
// Shared constants, types and the reciprocal table for the 3x3 mean filter.
// Used by the row store, the top level and the checker; depends on nothing else.

package mf3_pkg;

    // Longest image row that the row stores hold.
    localparam int MAX_WIDTH = 1024;

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int WCFG_W     = 11;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Derived widths: column index, used width, row counter, pending count.
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WU_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = HEIGHT_W + 1;
    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    // Neighborhood sum, neighbor count and reciprocal divide.
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Row store access: one read and one write-back per cycle.
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [PIX_W-1:0] wr_upper;
        logic [PIX_W-1:0] wr_middle;
    } mf3_mem_req_t;

    // Rounded-up 2^16 / count. The error term times the largest sum stays
    // below 2^16, so the truncated product equals the floor of the quotient.
    function automatic logic [RECIP_W-1:0] mf3_recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        m = '0;
        case (cnt)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/mf3_row_store.sv -----
// Row stores for the two image rows above the current one, kept side by side.
// Synchronous (registered) read with write-back forwarding.
// Depends on mf3_pkg.

module mf3_row_store
    import mf3_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mf3_mem_req_t      req,
    output logic [PIX_W-1:0]  upper_rd,
    output logic [PIX_W-1:0]  middle_rd
);

    logic [PIX_W-1:0] upper_row_store  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_row_store [MAX_WIDTH];

    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] middle_q_reg;
    logic             fwd_hit_reg;
    logic [PIX_W-1:0] fwd_upper_reg;
    logic [PIX_W-1:0] fwd_middle_reg;

    // Write-back of the shifted column.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            upper_row_store[req.wr_addr]  <= req.wr_upper;
            middle_row_store[req.wr_addr] <= req.wr_middle;
        end
    end

    // Read port; data is held while no new read is issued.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            upper_q_reg  <= upper_row_store[req.rd_addr];
            middle_q_reg <= middle_row_store[req.rd_addr];
        end
    end

    // A read that meets a write to the same entry takes the new data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (req.rd_en) begin
            fwd_hit_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            fwd_upper_reg  <= req.wr_upper;
            fwd_middle_reg <= req.wr_middle;
        end
    end

    assign upper_rd  = fwd_hit_reg ? fwd_upper_reg  : upper_q_reg;
    assign middle_rd = fwd_hit_reg ? fwd_middle_reg : middle_q_reg;

endmodule

// ----- rtl/mean_filter_3x3_border_aware.sv -----
// Top level of the border-aware 3x3 mean filter over a raster pixel stream.
// Depends on mf3_pkg and mf3_row_store.
//
//   Channel   Ports          Contents (lowest bit first)
//   input     s_t*           tdata: pixel[7:0]; tuser: drain
//   output    m_t*           tdata: smoothed[7:0]; tuser: end_of_row; tlast: end_of_frame
//   config    cfg_wr_*       index 0 image_width[10:0], index 1 image_height[15:0]
//
// One item is taken per cycle while s_tready is high; a result is registered in stage 1,
// stage 2 and then the output register. The first drain after a one-row frame
// visits the row store twice. The pace is set by the single row store port
// pair: one read and one write-back per cycle.
// Reset clears the counters and pipeline valids; the row stores are not cleared.
// With m_tready low, up to three results are held before s_tready falls.

module mean_filter_3x3_border_aware
    import mf3_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,      // pixel[7:0]
    input  logic [0:0]            s_tuser,      // drain
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,      // smoothed[7:0]
    output logic [0:0]            m_tuser,      // end_of_row
    output logic                  m_tlast,      // end_of_frame
    // Configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic eor;
        logic eof;
    } flags_t;

    // Configuration and position state.
    logic [WCFG_W-1:0]   image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [PEND_W-1:0]   pend_reg;
    logic                extra_reg;

    // Stage 1: row store data returns.
    logic                s1_valid_reg;
    logic                s1_res_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    flags_t              s1_flags_reg;
    logic [PIX_W-1:0]    win_reg [6];

    // Stage 2: sum and reciprocal.
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [RECIP_W-1:0]  s2_recip_reg;
    logic                s2_eor_reg;
    logic                s2_eof_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [PIX_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;
    logic                m_tlast_reg;

    // Flow control.
    logic out_free, s2_free, s1_go, accept;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_go    = !s1_valid_reg || !s1_res_reg || s2_free;
    assign s_tready = s1_go && !extra_reg;
    assign accept   = s_tvalid && s_tready;

    // Used width and height.
    logic [WU_W-1:0]     w_used;
    logic [HEIGHT_W-1:0] h_used;
    logic [ROW_W-1:0]    h_ext;

    always_comb begin
        if (image_width_reg == '0) begin
            w_used = WU_W'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            w_used = WU_W'(MAX_WIDTH);
        end else begin
            w_used = WU_W'(image_width_reg);
        end
        h_used = (image_height_reg == '0) ? HEIGHT_W'(1) : image_height_reg;
        h_ext  = {1'b0, h_used};
    end

    // Visit decision and border flags for the position being issued.
    logic             pix_item, drain_visit, visit, fresh, col_nz, res_valid;
    logic [COL_W-1:0] base_col, adv_col;
    logic [ROW_W-1:0] base_row, adv_row;
    logic [WU_W-1:0]  col_inc;
    logic [PEND_W-1:0] pend_set, pend_dec;
    flags_t           flags;

    always_comb begin
        pix_item    = accept && !s_tuser[0];
        drain_visit = (accept && s_tuser[0] && (pend_reg != '0)) || (extra_reg && s1_go);
        visit       = pix_item || drain_visit;
        fresh       = pix_item && ((pend_reg != '0) || (row_reg >= h_ext));
        base_col    = fresh ? '0 : col_reg;
        base_row    = fresh ? '0 : row_reg;
        col_nz      = (base_col != '0);

        res_valid      = col_nz ? (base_row >= ROW_W'(1)) : (base_row >= ROW_W'(2));
        flags.top_ok   = col_nz ? (base_row >= ROW_W'(2)) : (base_row >= ROW_W'(3));
        flags.bot_ok   = col_nz ? (base_row < h_ext) : (base_row <= h_ext);
        flags.left_ok  = col_nz ? (base_col >= COL_W'(2)) : (w_used >= WU_W'(2));
        flags.right_ok = col_nz;
        flags.eor      = !col_nz;
        flags.eof      = !col_nz && (base_row == h_ext + ROW_W'(1));

        col_inc = WU_W'(base_col) + WU_W'(1);
        if (col_inc >= w_used) begin
            adv_col = '0;
            adv_row = base_row + ROW_W'(1);
        end else begin
            adv_col = col_inc[COL_W-1:0];
            adv_row = base_row;
        end

        pend_set = (h_used == HEIGHT_W'(1)) ? PEND_W'(w_used) : PEND_W'(w_used) + PEND_W'(1);
        pend_dec = pend_reg - PEND_W'(1);
    end

    // Configuration writes and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= WCFG_W'(MAX_WIDTH);
            image_height_reg <= HEIGHT_W'(1);
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            extra_reg        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wr_data[WCFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                default: ;
            endcase
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            extra_reg <= 1'b0;
        end else if (pix_item) begin
            col_reg  <= adv_col;
            row_reg  <= adv_row;
            pend_reg <= (adv_row >= h_ext) ? pend_set : '0;
        end else if (drain_visit) begin
            if (res_valid) begin
                extra_reg <= 1'b0;
                if (pend_dec == '0) begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    pend_reg <= '0;
                end else begin
                    col_reg  <= adv_col;
                    row_reg  <= adv_row;
                    pend_reg <= pend_dec;
                end
            end else begin
                // The first drain of a one-row frame lands on no result;
                // a second visit follows in the next free cycle.
                col_reg   <= adv_col;
                row_reg   <= adv_row;
                extra_reg <= !extra_reg;
            end
        end
    end

    // Row store: read at the issued column, write back the shifted column.
    mf3_mem_req_t     mem_req;
    logic [PIX_W-1:0] upper_rd, middle_rd;
    logic [PIX_W-1:0] pix_in;

    assign pix_in = drain_visit ? '0 : s_tdata;

    always_comb begin
        mem_req.rd_en     = visit;
        mem_req.rd_addr   = base_col;
        mem_req.wr_en     = s1_valid_reg && s1_go;
        mem_req.wr_addr   = s1_addr_reg;
        mem_req.wr_upper  = middle_rd;
        mem_req.wr_middle = s1_pix_reg;
    end

    mf3_row_store u_row_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mem_req),
        .upper_rd  (upper_rd),
        .middle_rd (middle_rd)
    );

    // Stage 1 registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s1_valid_reg <= visit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && visit) begin
            s1_res_reg   <= res_valid;
            s1_pix_reg   <= pix_in;
            s1_addr_reg  <= base_col;
            s1_flags_reg <= flags;
        end
    end

    // Masked 3x3 sum and neighbor count.
    logic [PIX_W-1:0] tap [3][3];
    logic [2:0]       col_ok, row_ok;
    logic [1:0]       ncol, nrow;
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum_s1;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            tap[0][j] = win_reg[j];
            tap[1][j] = win_reg[3 + j];
        end
        tap[2][0] = upper_rd;
        tap[2][1] = middle_rd;
        tap[2][2] = s1_pix_reg;
        col_ok = {s1_flags_reg.right_ok, 1'b1, s1_flags_reg.left_ok};
        row_ok = {s1_flags_reg.bot_ok, 1'b1, s1_flags_reg.top_ok};
        ncol   = 2'd1 + 2'(s1_flags_reg.left_ok) + 2'(s1_flags_reg.right_ok);
        nrow   = 2'd1 + 2'(s1_flags_reg.top_ok) + 2'(s1_flags_reg.bot_ok);
        cnt    = CNT_W'(ncol) * CNT_W'(nrow);
        sum_s1 = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (col_ok[k] && row_ok[j]) begin
                    sum_s1 = sum_s1 + SUM_W'(tap[k][j]);
                end
            end
        end
    end

    // Window shift as the column leaves stage 1.
    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_go) begin
            for (int j = 0; j < 3; j++) begin
                win_reg[j] <= win_reg[3 + j];
            end
            win_reg[3] <= upper_rd;
            win_reg[4] <= middle_rd;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // Stage 2 registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_valid_reg && s1_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free && s1_valid_reg && s1_res_reg) begin
            s2_sum_reg   <= sum_s1;
            s2_recip_reg <= mf3_recip(cnt);
            s2_eor_reg   <= s1_flags_reg.eor;
            s2_eof_reg   <= s1_flags_reg.eof;
        end
    end

    // Divide by reciprocal multiply into the output register.
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(s2_sum_reg) * PROD_W'(s2_recip_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s2_valid_reg) begin
            m_tdata_reg <= prod[RECIP_SHIFT +: PIX_W];
            m_tuser_reg <= s2_eor_reg;
            m_tlast_reg <= s2_eof_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

// ----- rtl/mf3_checker.sv -----
// Port-level checks for the 3x3 mean filter, bound to its top level.
// Depends on mf3_pkg and mean_filter_3x3_border_aware.

module mf3_checker
    import mf3_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata,
    input logic [0:0]       m_tuser,
    input logic             m_tlast
);

    // The last pixel of the image is also the last pixel of its row.
    a_eof_is_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("end of frame without end of row");

    // Reset empties the output register.
    a_reset_no_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // After reset the input side is open for a transaction.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind mean_filter_3x3_border_aware mf3_checker u_mf3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
